### src/gmed_pkg.sv
// Shared types and constants for the gradient magnitude edge detector.
// Used by gmed_ctrl, gmed_dp and the top level; no dependencies.
package gmed_pkg;

	// Configuration register map
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS    = 1'd1;

	// Register field widths and reset values
	localparam int WIDTH_REG_W = 13;
	localparam int CHAN_REG_W  = 3;
	localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = 13'd640;
	localparam logic [CHAN_REG_W-1:0]  CHAN_RESET  = 3'd1;

	// Sample and result widths
	localparam int SAMPLE_W = 8;
	localparam int SUM_W    = 17;

	// Default build limits
	localparam int DEF_MAX_WIDTH    = 4096;
	localparam int DEF_MAX_CHANNELS = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POS,
		ST_RDA,
		ST_RDC,
		ST_CAPC,
		ST_SUM,
		ST_ROOT,
		ST_EMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic do_pos;
		logic rd_c;
		logic cap_a;
		logic cap_c;
		logic do_sum;
		logic root_step;
		logic out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic root_done;
		logic emit;
		logic out_free;
	} sts_t;

endpackage

### src/gmed_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the line store.
module gmed_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/gmed_ctrl.sv
// Sequencing state machine for the edge detector: one word at a time.
// Depends on gmed_pkg; drives commands into gmed_dp.
module gmed_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  gmed_pkg::sts_t sts,
	output gmed_pkg::cmd_t cmd
);
	import gmed_pkg::*;

	state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_nxt   = ST_POS;
				end
			end
			ST_POS: begin
				cmd.do_pos = 1'b1;
				state_nxt  = ST_RDA;
			end
			ST_RDA: begin
				state_nxt = ST_RDC;
			end
			ST_RDC: begin
				cmd.rd_c  = 1'b1;
				cmd.cap_a = 1'b1;
				state_nxt = ST_CAPC;
			end
			ST_CAPC: begin
				cmd.cap_c = 1'b1;
				state_nxt = ST_SUM;
			end
			ST_SUM: begin
				cmd.do_sum = 1'b1;
				state_nxt  = ST_ROOT;
			end
			ST_ROOT: begin
				if (sts.root_done) begin
					state_nxt = ST_EMIT;
				end else begin
					cmd.root_step = 1'b1;
				end
			end
			ST_EMIT: begin
				if (!sts.emit) begin
					state_nxt = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
		endcase
	end

endmodule

### src/gmed_dp.sv
// Datapath: config registers, row position, line store, squares and root.
// Depends on gmed_pkg and gmed_ram; commanded by gmed_ctrl.
module gmed_dp #(
	parameter int MAX_WIDTH    = gmed_pkg::DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = gmed_pkg::DEF_MAX_CHANNELS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [gmed_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [gmed_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [gmed_pkg::SAMPLE_W-1:0]      s_tdata,
	input  logic                               s_tuser,
	input  gmed_pkg::cmd_t                     cmd,
	output gmed_pkg::sts_t                     sts,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [gmed_pkg::SAMPLE_W-1:0]      m_tdata,
	output logic                               m_tlast
);
	import gmed_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RLW   = $clog2(DEPTH + 1);

	logic [WIDTH_REG_W-1:0] width_q;
	logic [CHAN_REG_W-1:0]  chan_q;
	logic [AW-1:0]          col_q;
	logic                   first_q;
	logic                   out_valid_q;

	logic [SAMPLE_W-1:0] sample_q;
	logic                fs_q;
	logic [AW-1:0]       col_cur_q;
	logic                emit_q;
	logic                edge_ok_q;
	logic                last_q;
	logic [SAMPLE_W-1:0] a_q;
	logic [SAMPLE_W-1:0] c_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] root_q;
	logic [SAMPLE_W-1:0] bit_q;
	logic [SAMPLE_W-1:0] out_data_q;
	logic                out_last_q;

	logic [RLW-1:0]        weff;
	logic [CHAN_REG_W-1:0] ceff;
	logic [RLW-1:0]        rowlen;
	logic [RLW-1:0]        col_pos;
	logic [RLW-1:0]        col_inc;
	logic                  first_pos;
	logic [AW-1:0]         ram_raddr;
	logic [SAMPLE_W-1:0]   ram_rdata;
	logic signed [SAMPLE_W:0]     dx;
	logic signed [SAMPLE_W:0]     dy;
	logic signed [2*SAMPLE_W+1:0] dx_sq;
	logic signed [2*SAMPLE_W+1:0] dy_sq;
	logic [SAMPLE_W-1:0]   trial;
	logic [2*SAMPLE_W-1:0] trial_sq;
	logic [SAMPLE_W-1:0]   edge_val;

	// Clamp registers to the supported range; row length in bytes
	always_comb begin
		if (width_q < WIDTH_REG_W'(2)) begin
			weff = RLW'(2);
		end else if (32'(width_q) > MAX_WIDTH) begin
			weff = RLW'(MAX_WIDTH);
		end else begin
			weff = RLW'(width_q);
		end
		if (chan_q == '0) begin
			ceff = CHAN_REG_W'(1);
		end else if (32'(chan_q) > MAX_CHANNELS) begin
			ceff = CHAN_REG_W'(MAX_CHANNELS);
		end else begin
			ceff = chan_q;
		end
		rowlen = RLW'(weff * RLW'(ceff));
	end

	// Position of the current word, after frame start and wrap
	always_comb begin
		col_pos   = fs_q ? '0 : RLW'(col_q);
		first_pos = fs_q | first_q;
		if (col_pos >= rowlen) begin
			col_pos = '0;
		end
		col_inc = col_pos + RLW'(1);
	end

	// Config registers, row position and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WIDTH_RESET;
			chan_q      <= CHAN_RESET;
			col_q       <= '0;
			first_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_IMAGE_WIDTH: width_q <= cfg_data[WIDTH_REG_W-1:0];
					CFG_CHANNELS:    chan_q  <= cfg_data[CHAN_REG_W-1:0];
				endcase
			end
			if (cmd.do_pos) begin
				if (col_inc >= rowlen) begin
					col_q   <= '0;
					first_q <= 1'b0;
				end else begin
					col_q   <= col_inc[AW-1:0];
					first_q <= first_pos;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Line store: read A at column, C one pixel right, then write sample
	assign ram_raddr = cmd.rd_c ? col_cur_q + AW'(ceff) : col_cur_q;

	gmed_ram #(
		.DATA_W (SAMPLE_W),
		.DEPTH  (DEPTH)
	) u_line (
		.clk   (clk),
		.we    (cmd.do_sum),
		.waddr (col_cur_q),
		.wdata (sample_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Differences and squares
	assign dx    = $signed({1'b0, a_q}) - $signed({1'b0, sample_q});
	assign dy    = $signed({1'b0, a_q}) - $signed({1'b0, c_q});
	assign dx_sq = dx * dx;
	assign dy_sq = dy * dy;

	// Square root, one result bit per step
	assign trial    = root_q | bit_q;
	assign trial_sq = trial * trial;

	always_comb begin
		if (!edge_ok_q) begin
			edge_val = '0;
		end else if (sum_q[SUM_W-1]) begin
			edge_val = '1;
		end else begin
			edge_val = root_q;
		end
	end

	// Per-word payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sample_q <= s_tdata;
			fs_q     <= s_tuser;
		end
		if (cmd.do_pos) begin
			col_cur_q <= col_pos[AW-1:0];
			emit_q    <= !first_pos;
			edge_ok_q <= !first_pos && ((col_pos + RLW'(ceff)) < rowlen);
			last_q    <= (col_inc == rowlen);
		end
		if (cmd.cap_a) begin
			a_q <= ram_rdata;
		end
		if (cmd.cap_c) begin
			c_q <= ram_rdata;
		end
		if (cmd.do_sum) begin
			sum_q  <= SUM_W'($unsigned(dx_sq)) + SUM_W'($unsigned(dy_sq));
			root_q <= '0;
			bit_q  <= {1'b1, {(SAMPLE_W-1){1'b0}}};
		end
		if (cmd.root_step) begin
			if (trial_sq <= sum_q[2*SAMPLE_W-1:0]) begin
				root_q <= trial;
			end
			bit_q <= bit_q >> 1;
		end
		if (cmd.out_load) begin
			out_data_q <= edge_val;
			out_last_q <= last_q;
		end
	end

	// Status and output word
	assign sts.root_done = (bit_q == '0);
	assign sts.emit      = emit_q;
	assign sts.out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

### src/gradient_magnitude_edge_detect_top.sv
// Gradient magnitude edge detector, one row line store, top level.
// The controller takes a new input word only after its sequence of
// two line store reads, one square step and eight square root steps; a full
// output register that is not drained holds the sequence.
// arst_n resets the controller, config registers, position, first-row flag and
// output valid; the line store is not cleared and needs no clearing pass.
module gradient_magnitude_edge_detect_top #(
	parameter int MAX_WIDTH    = gmed_pkg::DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = gmed_pkg::DEF_MAX_CHANNELS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [gmed_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gmed_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,  // [7:0] sample
	input  logic                            s_tuser,  // [0] frame_start
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,  // [7:0] edge_value
	output logic                            m_tlast   // row_end
);
	import gmed_pkg::*;

	cmd_t cmd;
	sts_t sts;

	gmed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gmed_dp #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
